### rtl/core/scc_pkg.sv
// Shared types and constants for the settable clock calendar.
package scc_pkg;

	localparam logic [7:0] TPS_RESET = 8'd10;

	localparam logic [2:0] MODE_RUN   = 3'd0;
	localparam logic [2:0] MODE_HOUR  = 3'd1;
	localparam logic [2:0] MODE_MIN   = 3'd2;
	localparam logic [2:0] MODE_DAY   = 3'd3;
	localparam logic [2:0] MODE_MONTH = 3'd4;
	localparam logic [2:0] MODE_YEAR  = 3'd5;
	localparam logic [2:0] MODE_AHOUR = 3'd6;
	localparam logic [2:0] MODE_AMIN  = 3'd7;

	typedef struct packed {
		logic tick;
		logic set_pressed;
		logic up_pressed;
		logic down_pressed;
	} in_t;

	typedef struct packed {
		logic [5:0]  sec_out;
		logic [5:0]  min_out;
		logic [4:0]  hour_out;
		logic [4:0]  day_out;
		logic [3:0]  month_out;
		logic [11:0] year_out;
		logic [2:0]  mode_out;
		logic [4:0]  alarm_hour_out;
		logic [5:0]  alarm_min_out;
	} out_t;

endpackage

### rtl/core/scc_in_stage.sv
// Input register stage: holds one accepted beat until the update consumes it.
module scc_in_stage (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  scc_pkg::in_t in_data,
	input  logic         advance,
	output logic         valid_s1,
	output scc_pkg::in_t item_s1
);
	import scc_pkg::*;

	logic load;

	assign in_stall = valid_s1 & ~advance;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_data;
		end
	end

endmodule

### rtl/core/scc_update.sv
// Clock, calendar, mode and nudge state with its single-pass next-state logic.
module scc_update (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  scc_pkg::in_t  item_s1,
	input  logic [7:0]    tps,
	output scc_pkg::out_t result
);
	import scc_pkg::*;

	logic [7:0]  subsec_q, subsec_n, cnt_inc, rate;
	logic [5:0]  sec_q, min_q, amin_q;
	logic [4:0]  hour_q, day_q, ahour_q;
	logic [3:0]  month_q;
	logic [11:0] year_q;
	logic [2:0]  mode_q, mode_n;
	logic        started_q, started_n;

	logic        sec_step, min_step, hour_step, day_step, month_step, year_step;
	logic [5:0]  sec_c, min_c, min_n, amin_n;
	logic [4:0]  hour_c, day_c, hour_n, day_n, ahour_n;
	logic [3:0]  month_c, month_n;
	logic [11:0] year_c, year_n;
	logic        up, down;

	function automatic logic [11:0] nudge(input logic [11:0] v, input logic [11:0] lo,
			input logic [11:0] hi, input logic inc, input logic dec);
		logic [11:0] v1;
		v1 = (inc && v < hi) ? v + 12'd1 : v;
		return (dec && v1 > lo) ? v1 - 12'd1 : v1;
	endfunction

	always_comb begin
		cnt_inc  = subsec_q + 8'd1;
		rate     = (tps == 8'd0) ? 8'd1 : tps;
		sec_step = item_s1.tick & ((cnt_inc >= rate) | (cnt_inc == 8'd0));
		subsec_n = item_s1.tick ? (sec_step ? 8'd0 : cnt_inc) : subsec_q;

		min_step   = sec_step & (sec_q == 6'd59);
		hour_step  = min_step & (min_q == 6'd59);
		day_step   = hour_step & (hour_q == 5'd23);
		month_step = day_step & (day_q == 5'd31);
		year_step  = month_step & (month_q == 4'd12);

		sec_c   = sec_step ? (min_step ? 6'd0 : sec_q + 6'd1) : sec_q;
		min_c   = min_step ? (hour_step ? 6'd0 : min_q + 6'd1) : min_q;
		hour_c  = hour_step ? (day_step ? 5'd0 : hour_q + 5'd1) : hour_q;
		day_c   = day_step ? (month_step ? 5'd1 : day_q + 5'd1) : day_q;
		month_c = month_step ? (year_step ? 4'd1 : month_q + 4'd1) : month_q;
		year_c  = year_step ? ((year_q >= 12'd2099) ? 12'd2000 : year_q + 12'd1) : year_q;

		started_n = started_q | item_s1.tick;
		mode_n    = (started_n && item_s1.set_pressed) ? mode_q + 3'd1 : mode_q;
		up        = started_n & item_s1.up_pressed;
		down      = started_n & item_s1.down_pressed;

		hour_n  = hour_c;
		min_n   = min_c;
		day_n   = day_c;
		month_n = month_c;
		year_n  = year_c;
		ahour_n = ahour_q;
		amin_n  = amin_q;
		case (mode_n)
			MODE_HOUR:  hour_n  = 5'(nudge(12'(hour_c), 12'd0, 12'd23, up, down));
			MODE_MIN:   min_n   = 6'(nudge(12'(min_c), 12'd0, 12'd59, up, down));
			MODE_DAY:   day_n   = 5'(nudge(12'(day_c), 12'd1, 12'd31, up, down));
			MODE_MONTH: month_n = 4'(nudge(12'(month_c), 12'd1, 12'd12, up, down));
			MODE_YEAR:  year_n  = nudge(year_c, 12'd2000, 12'd2099, up, down);
			MODE_AHOUR: ahour_n = 5'(nudge(12'(ahour_q), 12'd0, 12'd23, up, down));
			MODE_AMIN:  amin_n  = 6'(nudge(12'(amin_q), 12'd0, 12'd59, up, down));
			default: ;
		endcase

		result.sec_out        = sec_c;
		result.min_out        = min_n;
		result.hour_out       = hour_n;
		result.day_out        = day_n;
		result.month_out      = month_n;
		result.year_out       = year_n;
		result.mode_out       = mode_n;
		result.alarm_hour_out = ahour_n;
		result.alarm_min_out  = amin_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subsec_q  <= 8'd0;
			sec_q     <= 6'd0;
			min_q     <= 6'd0;
			hour_q    <= 5'd0;
			day_q     <= 5'd1;
			month_q   <= 4'd1;
			year_q    <= 12'd2023;
			mode_q    <= MODE_RUN;
			ahour_q   <= 5'd0;
			amin_q    <= 6'd0;
			started_q <= 1'b0;
		end else if (advance) begin
			subsec_q  <= subsec_n;
			sec_q     <= sec_c;
			min_q     <= min_n;
			hour_q    <= hour_n;
			day_q     <= day_n;
			month_q   <= month_n;
			year_q    <= year_n;
			mode_q    <= mode_n;
			ahour_q   <= ahour_n;
			amin_q    <= amin_n;
			started_q <= started_n;
		end
	end

endmodule

### rtl/core/scc_out_stage.sv
// Result register: holds the updated time and settings until the beat is taken.
module scc_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  scc_pkg::out_t result,
	output logic          advance,
	output logic          out_valid,
	input  logic          out_stall,
	output scc_pkg::out_t out_data
);
	import scc_pkg::*;

	assign advance = valid_s1 & (~out_valid | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= result;
		end
	end

endmodule

### rtl/core/settable_clock_calendar.sv
// Settable clock calendar: top level with the prescale register and the three stages.
// Every input beat is one sampling period and yields exactly one result beat holding the
// time, date, mode and alarm after that period. A beat goes through an input register and
// one pass of update logic into the result register, and one beat per cycle is sustained while
// out_stall is low, with the result register taking the next beat in the cycle its waiting
// result is taken. ticks_per_second is written through cfg_wr_en/cfg_wr_data (reset 10; zero
// counts as one) and should change only while no beat is in flight.
module settable_clock_calendar (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [7:0]    cfg_wr_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  scc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output scc_pkg::out_t out_data
);
	import scc_pkg::*;

	logic [7:0] tps_q;
	logic       advance;
	logic       valid_s1;
	in_t        item_s1;
	out_t       result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_wr_en) begin
			tps_q <= cfg_wr_data;
		end
	end

	scc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	scc_update u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.tps     (tps_q),
		.result  (result)
	);

	scc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### tb/calendar_tb_pkg.sv
// Scoreboard class for the settable clock calendar testbench: clock predictor and readout checks.
package calendar_tb_pkg;
	import scc_pkg::*;

	class calendar_scoreboard;
		logic [7:0]  rate;
		logic [7:0]  prescale;
		logic [5:0]  sec;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic [2:0]  mode;
		logic [4:0]  alarm_hour;
		logic [5:0]  alarm_min;
		bit          running;
		out_t        pending_readouts[$];
		int          errors;

		function new();
			rate = TPS_RESET;
			prescale = '0;
			sec = '0;
			minute = '0;
			hour = '0;
			day = 5'd1;
			month = 4'd1;
			year = 12'd2023;
			mode = MODE_RUN;
			alarm_hour = '0;
			alarm_min = '0;
			running = 1'b0;
			errors = 0;
		endfunction

		function int pending();
			return pending_readouts.size();
		endfunction

		function int nudged(int v, int lo, int hi, bit up, bit down);
			if (up && v < hi)
				v++;
			if (down && v > lo)
				v--;
			return v;
		endfunction

		function void advance_second();
			bit carry;
			carry = sec == 6'd59;
			sec = carry ? 6'd0 : sec + 6'd1;
			if (carry) begin
				carry = minute == 6'd59;
				minute = carry ? 6'd0 : minute + 6'd1;
			end
			if (carry) begin
				carry = hour == 5'd23;
				hour = carry ? 5'd0 : hour + 5'd1;
			end
			if (carry) begin
				carry = day == 5'd31;
				day = carry ? 5'd1 : day + 5'd1;
			end
			if (carry) begin
				carry = month == 4'd12;
				month = carry ? 4'd1 : month + 4'd1;
			end
			if (carry)
				year = (year == 12'd2099) ? 12'd2000 : year + 12'd1;
		endfunction

		// one sampling period: prescaler and carry, then set button, then nudge
		function void accept_sample(in_t s);
			logic [7:0] count;
			out_t r;
			if (s.tick) begin
				running = 1'b1;
				count = prescale + 8'd1;
				if (count >= ((rate == 8'd0) ? 8'd1 : rate) || count == 8'd0) begin
					count = 8'd0;
					advance_second();
				end
				prescale = count;
			end
			if (running) begin
				if (s.set_pressed)
					mode = mode + 3'd1;
				case (mode)
					MODE_HOUR:  hour = 5'(nudged(int'(hour), 0, 23, s.up_pressed,
						s.down_pressed));
					MODE_MIN:   minute = 6'(nudged(int'(minute), 0, 59, s.up_pressed,
						s.down_pressed));
					MODE_DAY:   day = 5'(nudged(int'(day), 1, 31, s.up_pressed,
						s.down_pressed));
					MODE_MONTH: month = 4'(nudged(int'(month), 1, 12, s.up_pressed,
						s.down_pressed));
					MODE_YEAR:  year = 12'(nudged(int'(year), 2000, 2099, s.up_pressed,
						s.down_pressed));
					MODE_AHOUR: alarm_hour = 5'(nudged(int'(alarm_hour), 0, 23, s.up_pressed,
						s.down_pressed));
					MODE_AMIN:  alarm_min = 6'(nudged(int'(alarm_min), 0, 59, s.up_pressed,
						s.down_pressed));
					default: ;
				endcase
			end
			r.sec_out = sec;
			r.min_out = minute;
			r.hour_out = hour;
			r.day_out = day;
			r.month_out = month;
			r.year_out = year;
			r.mode_out = mode;
			r.alarm_hour_out = alarm_hour;
			r.alarm_min_out = alarm_min;
			pending_readouts.push_back(r);
		endfunction

		function void compare(string name, logic [11:0] want, logic [11:0] got);
			if (want !== got) begin
				$error("%s expected %0d got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_readout(out_t got);
			out_t want;
			if (pending_readouts.size() == 0) begin
				$error("readout beat with no sample pending");
				errors++;
				return;
			end
			want = pending_readouts.pop_front();
			compare("sec_out", 12'(want.sec_out), 12'(got.sec_out));
			compare("min_out", 12'(want.min_out), 12'(got.min_out));
			compare("hour_out", 12'(want.hour_out), 12'(got.hour_out));
			compare("day_out", 12'(want.day_out), 12'(got.day_out));
			compare("month_out", 12'(want.month_out), 12'(got.month_out));
			compare("year_out", want.year_out, got.year_out);
			compare("mode_out", 12'(want.mode_out), 12'(got.mode_out));
			compare("alarm_hour_out", 12'(want.alarm_hour_out), 12'(got.alarm_hour_out));
			compare("alarm_min_out", 12'(want.alarm_min_out), 12'(got.alarm_min_out));
		endfunction
	endclass

endpackage

### tb/testbench.sv
// Top-level testbench for settable_clock_calendar: drives samples, stalls readouts, checks them.
module testbench;
	import scc_pkg::*;
	import calendar_tb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// tick, set, up, down
	localparam logic [3:0] OPENING [25] = '{
		4'b0111, 4'b0100, 4'b0010, 4'b0001,
		4'b1000,
		4'b0100, 4'b0010, 4'b0001, 4'b0001, 4'b0011,
		4'b0110, 4'b0101, 4'b0110, 4'b0101, 4'b0110, 4'b0111,
		4'b1110,
		4'b1110, 4'b1011,
		4'b1000, 4'b1000, 4'b1000, 4'b1000, 4'b1000, 4'b1000
	};

	typedef enum int {STALL_NONE, STALL_SOME, STALL_HEAVY} stall_style_e;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [7:0]   cfg_wr_data = '0;
	logic         in_valid = 1'b0;
	logic         in_stall;
	in_t          in_data = '0;
	logic         out_valid;
	logic         out_stall = 1'b0;
	out_t         out_data;
	int           cycles = 0;
	int           burst_left = 0;
	int           beats_sent = 0;
	stall_style_e stall_style = STALL_NONE;

	calendar_scoreboard calendar = new();

	settable_clock_calendar u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 50 == 0)
			stall_style <= stall_style_e'($urandom_range(0, 2));
		case (stall_style)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_SOME:  out_stall <= $urandom_range(0, 3) == 0;
			default:     out_stall <= $urandom_range(0, 3) != 0;
		endcase
		if (arst_n && out_valid && !out_stall)
			calendar.check_readout(out_data);
		if (cycles == CYCLE_LIMIT) begin
			$display("settable_clock_calendar verification failed");
			$finish;
		end
	end

	function automatic in_t sample(bit t, bit s, bit u, bit d);
		return in_t'({t, s, u, d});
	endfunction

	task automatic send_beat(input in_t s);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 30);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		calendar.accept_sample(s);
		beats_sent++;
	endtask

	task automatic steer_to(input logic [2:0] target);
		while (calendar.mode != target)
			send_beat(sample(1'b0, 1'b1, 1'b0, 1'b0));
	endtask

	task automatic press(input int n, input bit up, input bit down);
		repeat (n) send_beat(sample(1'b0, 1'b0, up, down));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (calendar.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_rate(input logic [7:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		calendar.rate = v;
	endtask

	// max out hour, minute and date fields, carry seconds into the year, then nudge the year down
	task automatic roll_calendar_over();
		steer_to(MODE_HOUR);
		press(24, 1'b1, 1'b0);
		steer_to(MODE_MIN);
		press(60, 1'b1, 1'b0);
		steer_to(MODE_DAY);
		press(31, 1'b1, 1'b0);
		steer_to(MODE_MONTH);
		press(12, 1'b1, 1'b0);
		steer_to(MODE_YEAR);
		press(100, 1'b1, 1'b0);
		steer_to(MODE_RUN);
		repeat (61) send_beat(sample(1'b1, 1'b0, 1'b0, 1'b0));
		steer_to(MODE_YEAR);
		press(3, 1'b0, 1'b1);
	endtask

	task automatic random_stretch(input int count);
		int stop_at;
		int len;
		int dir;
		in_t s;
		stop_at = beats_sent + count;
		while (beats_sent < stop_at) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					len = $urandom_range(5, 40);
					repeat (len) begin
						s = sample($urandom_range(0, 3) != 0, $urandom_range(0, 15) == 0,
							$urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0);
						send_beat(s);
					end
				end
				2: begin
					steer_to(3'($urandom_range(0, 7)));
					dir = $urandom_range(0, 3);
					len = $urandom_range(1, 30);
					repeat (len) begin
						s = sample($urandom_range(0, 3) == 0, 1'b0,
							(dir == 3) ? 1'($urandom_range(0, 1)) : dir != 1,
							(dir == 3) ? 1'($urandom_range(0, 1)) : dir != 0);
						send_beat(s);
					end
				end
				default: begin
					repeat ($urandom_range(1, 10))
						send_beat(in_t'(4'($urandom_range(0, 15))));
				end
			endcase
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (OPENING[i])
			send_beat(in_t'(OPENING[i]));
		random_stretch(30);
		write_rate(8'd1);
		roll_calendar_over();
		random_stretch(30);
		write_rate(8'd255);
		repeat (270) send_beat(sample(1'b1, 1'b0, 1'b0, 1'b0));
		// prescaler sits well above the new rate
		write_rate(8'd3);
		random_stretch(30);
		write_rate(8'd0);
		random_stretch(30);
		settle();
		if (calendar.errors == 0)
			$display("settable_clock_calendar verification clean");
		else
			$display("settable_clock_calendar verification failed");
		$finish;
	end

endmodule
